/* hw/rtl/mtcr_pkg.sv */
// Package for the machine timer compare registers
// Holds the transaction structs, operation codes, register offsets and decode struct
// No dependencies
package mtcr_pkg;

    // bus operation codes
    typedef enum logic [1:0] {
        OP_READ32  = 2'd0,
        OP_READ64  = 2'd1,
        OP_WRITE32 = 2'd2,
        OP_WRITE64 = 2'd3
    } op_t;

    // register offsets within the device region
    localparam logic [15:0] CMP_BASE  = 16'h4000;
    localparam logic [15:0] TIME_LO_A = 16'h7ff8;
    localparam logic [15:0] TIME_LO_B = 16'hbff8;
    localparam logic [15:0] TIME_HI_A = 16'h7ffc;
    localparam logic [15:0] TIME_HI_B = 16'hbffc;

    // width of the active hart count register
    localparam int ACTIVE_W = 7;
    // widest hart index the decoder reports
    localparam int HART_IDX_W = 6;
    // harts shown in the pending vector
    localparam int PEND_W = 8;

    // request transaction
    typedef struct packed {
        op_t          operation;
        logic [15:0]  offset;
        logic [63:0]  write_data;
    } req_t;

    // response transaction
    typedef struct packed {
        logic [63:0]         read_data;
        logic [PEND_W-1:0]   timer_pending;
    } rsp_t;

    // decoded 32-bit word address
    typedef struct packed {
        logic                   cmp_hit;
        logic                   cmp64;
        logic                   cmp_hi;
        logic                   time_lo;
        logic                   time_hi;
        logic [HART_IDX_W-1:0]  hart;
    } dec_t;

endpackage

/* hw/rtl/mtcr_decode.sv */
// Address decoder for the machine timer compare registers
// Maps a 17-bit byte address onto the compare and time words
// Depends on mtcr_pkg
module mtcr_decode
    import mtcr_pkg::*;
#(
    parameter int HARTS = 8
)
(
    input  logic [16:0] addr,
    output dec_t        dec
);

    localparam int CmpEnd  = 16'h4000 + HARTS * 8;
    localparam int CmpLast = 16'h4000 + (HARTS - 1) * 8;

    logic [16:0] rel;
    logic        above_base;

    // offset relative to the compare window
    assign rel        = addr - {1'b0, CMP_BASE};
    assign above_base = addr >= {1'b0, CMP_BASE};

    // word decode
    always_comb
    begin
        dec.cmp_hit = above_base && (addr < 17'(CmpEnd));
        dec.cmp64   = above_base && (addr <= 17'(CmpLast));
        dec.cmp_hi  = rel[2];
        dec.hart    = rel[3 +: HART_IDX_W];
        dec.time_lo = (addr == {1'b0, TIME_LO_A}) || (addr == {1'b0, TIME_LO_B});
        dec.time_hi = (addr == {1'b0, TIME_HI_A}) || (addr == {1'b0, TIME_HI_B});
    end

endmodule

/* hw/rtl/mtcr_regs.sv */
// Time and compare register file with per-hart pending comparators
// Decodes both halves of an access, applies writes and forms the response
// Depends on mtcr_pkg and mtcr_decode
module mtcr_regs
    import mtcr_pkg::*;
#(
    parameter int HARTS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  req_t                req,
    input  logic [ACTIVE_W-1:0] active_harts,
    output rsp_t                rsp
);

    localparam int HW = (HARTS > 1) ? $clog2(HARTS) : 1;

    logic [63:0]       time_reg;
    logic [63:0]       time_next;
    logic [63:0]       cmp_reg  [HARTS];
    logic [63:0]       cmp_next [HARTS];
    logic [HARTS-1:0]  pend_reg;
    logic [HARTS-1:0]  pend_next;

    dec_t              d0;
    dec_t              d1;
    logic [HW-1:0]     idx;
    logic [63:0]       sel;
    logic [31:0]       word0;
    logic [31:0]       word1;
    logic [63:0]       wd;

    logic              is_write;
    logic              is_w64;
    logic              full_cmp;
    logic              full_time;
    logic              s0;
    logic              s1;
    logic              s0_cmp_lo;
    logic              s0_cmp_hi;
    logic              cmp_lo_we;
    logic              cmp_hi_we;
    logic              time_lo_we;
    logic              time_hi_we;
    logic [31:0]       cmp_lo_val;
    logic [31:0]       cmp_hi_val;
    logic [31:0]       time_lo_val;
    logic [31:0]       time_hi_val;
    logic              wr_any;
    logic [PEND_W-1:0] pend_vec;

    // decode of the access and of its upper half
    mtcr_decode #(.HARTS(HARTS)) u_dec_lo
    (
        .addr (({1'b0, req.offset})),
        .dec  (d0)
    );

    mtcr_decode #(.HARTS(HARTS)) u_dec_hi
    (
        .addr (({1'b0, req.offset} + 17'd4)),
        .dec  (d1)
    );

    assign wd = req.write_data;

    // one compare entry serves both halves: the lower half's hart if it hits, else the upper's
    assign idx = d0.cmp_hit ? d0.hart[HW-1:0] : d1.hart[HW-1:0];
    assign sel = cmp_reg[idx];

    // 32-bit word reads
    always_comb
    begin
        if (d0.cmp_hit)
            word0 = d0.cmp_hi ? sel[63:32] : sel[31:0];
        else if (d0.time_lo)
            word0 = time_reg[31:0];
        else if (d0.time_hi)
            word0 = time_reg[63:32];
        else
            word0 = '0;

        if (d1.cmp_hit)
            word1 = d1.cmp_hi ? sel[63:32] : sel[31:0];
        else if (d1.time_lo)
            word1 = time_reg[31:0];
        else if (d1.time_hi)
            word1 = time_reg[63:32];
        else
            word1 = '0;
    end

    // read data
    always_comb
    begin
        unique case (req.operation)
            OP_READ32:
                rsp.read_data = {32'd0, word0};
            OP_READ64:
            begin
                if (d0.cmp64)
                    rsp.read_data = sel;
                else if (d0.time_lo)
                    rsp.read_data = time_reg;
                else
                    rsp.read_data = {word1, word0};
            end
            OP_WRITE32,
            OP_WRITE64:
                rsp.read_data = '0;
            default:
                rsp.read_data = '0;
        endcase
    end

    // write enables: whole 64-bit register, or up to two separate words
    always_comb
    begin
        is_write  = en && ((req.operation == OP_WRITE32) || (req.operation == OP_WRITE64));
        is_w64    = en && (req.operation == OP_WRITE64);
        full_cmp  = is_w64 && d0.cmp64;
        full_time = is_w64 && d0.time_lo;
        s0        = is_write && !full_cmp && !full_time;
        s1        = is_w64 && !full_cmp && !full_time;
        s0_cmp_lo = s0 && d0.cmp_hit && !d0.cmp_hi;
        s0_cmp_hi = s0 && d0.cmp_hit && d0.cmp_hi;

        cmp_lo_we  = full_cmp || s0_cmp_lo || (s1 && d1.cmp_hit && !d1.cmp_hi);
        cmp_hi_we  = full_cmp || s0_cmp_hi || (s1 && d1.cmp_hit && d1.cmp_hi);
        cmp_lo_val = (full_cmp || s0_cmp_lo) ? wd[31:0] : wd[63:32];
        cmp_hi_val = full_cmp ? wd[63:32] : (s0_cmp_hi ? wd[31:0] : wd[63:32]);

        time_lo_we  = full_time || (s0 && d0.time_lo) || (s1 && d1.time_lo);
        time_hi_we  = full_time || (s0 && d0.time_hi) || (s1 && d1.time_hi);
        time_lo_val = (full_time || (s0 && d0.time_lo)) ? wd[31:0] : wd[63:32];
        time_hi_val = full_time ? wd[63:32] : ((s0 && d0.time_hi) ? wd[31:0] : wd[63:32]);

        wr_any = cmp_lo_we || cmp_hi_we || time_lo_we || time_hi_we;
    end

    // next register state
    always_comb
    begin
        time_next = time_reg;
        if (time_lo_we)
            time_next[31:0] = time_lo_val;
        if (time_hi_we)
            time_next[63:32] = time_hi_val;

        for (int i = 0; i < HARTS; i++)
        begin
            cmp_next[i] = cmp_reg[i];
        end
        if (cmp_lo_we)
            cmp_next[idx][31:0] = cmp_lo_val;
        if (cmp_hi_we)
            cmp_next[idx][63:32] = cmp_hi_val;
    end

    // per-hart comparators on the updated state, for harts below the active count on a mapped write
    always_comb
    begin
        for (int i = 0; i < HARTS; i++)
        begin
            if (wr_any && (ACTIVE_W'(i) < active_harts))
                pend_next[i] = time_next >= cmp_next[i];
            else
                pend_next[i] = pend_reg[i];
        end
    end

    // visible pending vector, zero above the hart count
    generate
        for (genvar k = 0; k < PEND_W; k++)
        begin : g_pend
            if (k < HARTS)
            begin : g_hart
                assign pend_vec[k] = pend_next[k];
            end
            else
            begin : g_none
                assign pend_vec[k] = 1'b0;
            end
        end
    endgenerate

    assign rsp.timer_pending = pend_vec;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            pend_reg <= '0;
            for (int i = 0; i < HARTS; i++)
            begin
                cmp_reg[i] <= '1;
            end
        end
        else
        begin
            time_reg <= time_next;
            pend_reg <= pend_next;
            for (int i = 0; i < HARTS; i++)
            begin
                cmp_reg[i] <= cmp_next[i];
            end
        end
    end

    // a transaction that writes nothing mapped leaves time and pending flags alone
    assert property (@(posedge clk) disable iff (!rst_n)
        en && !wr_any |=> $stable(time_reg) && $stable(pend_reg))
        else $error("unmapped or read transaction changed timer state");

    // a whole 64-bit time write lands in one go
    assert property (@(posedge clk) disable iff (!rst_n)
        full_time |=> time_reg == $past(req.write_data))
        else $error("64-bit time write lost data");

    // 32-bit reads are zero extended
    assert property (@(posedge clk) disable iff (!rst_n)
        en && (req.operation == OP_READ32) |-> rsp.read_data[63:32] == 32'd0)
        else $error("32-bit read not zero extended");

endmodule

/* hw/rtl/machine_timer_compare_registers.sv */
// Machine timer compare registers: top level with input and result registers
// Holds the active hart count register and the transaction pipeline
// Depends on mtcr_pkg and mtcr_regs
//
// Usage:
//   req channel (req_valid, req_stall, req): one 32- or 64-bit bus read or
//   write per transaction. rsp channel (rsp_valid, rsp_stall, rsp): one
//   response per request with the read data and the timer pending vector
//   after the access has taken effect.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes the number of harts
//   whose pending flags follow a write; always ready, write it while idle.
//   A request passes the input register, then the register file access and
//   the parallel comparators load the result register. One transaction per
//   cycle is sustained while rsp_stall is low.
//   When rsp_stall is high the response holds; the input register still
//   takes one more request, after which req_stall rises.
//   Reset clears time to zero, all compares to all ones, pending flags to
//   zero and the active hart count to eight. No clearing pass is needed.
module machine_timer_compare_registers
    import mtcr_pkg::*;
#(
    parameter int HARTS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ACTIVE_W-1:0] cfg_data
);

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

    logic                req_valid_reg;
    logic                req_valid_next;
    req_t                req_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_comb;
    logic [ACTIVE_W-1:0] active_reg;
    logic                advance;
    logic                req_take;

    // pipeline control
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        req_valid_next = req_take || (req_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);
    end

    // register file and comparators
    mtcr_regs #(.HARTS(HARTS)) u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .req          (req_reg),
        .active_harts (active_reg),
        .rsp          (rsp_comb)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            active_reg    <= ACTIVE_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                active_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req;
        if (advance)
            rsp_reg <= rsp_comb;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a held request stays in the input register until it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg)
        else $error("request dropped from input register");

    // a stalled response holds its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled response changed");

    // the input side only stalls while the input register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> req_valid_reg)
        else $error("request stalled with empty input register");

endmodule
